// ===== rtl/ole_pkg.sv =====
// Shared types and codes of the ordered list engine.
package ole_pkg;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_FIND   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_NOTFOUND = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned COUNT_W  = 7;

endpackage

// ===== rtl/ole_ram.sv =====
// Simple dual-port synchronous RAM holding the list entries, registered read.
module ole_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine: positional list of signed 32-bit entries held in one RAM.
// An append or a rejected insert or pop goes straight to the completion state; an insert
// shifts entries up, a pop shifts them down, and a remove or find scans from the front,
// a remove then shifting the later entries down. One request is worked on at a time; the
// next is taken in the cycle after the result is loaded, and a held result stalls.
// Reset clears the entry count and the handshake state; the RAM is not cleared.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // req_type[2:0], position[9:3], item_value[41:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[1:0], popped_value[33:2], found_index[40:34],
                                  // entry_count[47:41]
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;

    ole_pkg::state_t  state_reg, state_next;
    ole_pkg::op_t     op_reg, op_next;
    ole_pkg::status_t status_reg, status_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic               pend_reg, pend_next;
    logic               cap_reg, cap_next;
    logic [31:0]        val_reg, val_next;
    logic [31:0]        popped_reg, popped_next;
    logic [6:0]         idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [47:0]        m_data_reg, m_data_next;

    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [31:0]        mem_wdata, mem_rdata;

    logic [CMP_W-1:0]   pos_cmp, cnt_cmp;
    logic [CNT_W-1:0]   ptr_dec;
    logic               full;

    ole_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (32)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign pos_cmp = CMP_W'(s_tdata[9:3]);
    assign cnt_cmp = CMP_W'(count_reg);
    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    assign s_tready = (state_reg == ole_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ole_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            cap_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        paddr_reg  <= paddr_next;
        val_reg    <= val_next;
        popped_reg <= popped_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        paddr_next   = paddr_reg;
        pend_next    = pend_reg;
        cap_next     = cap_reg;
        val_next     = val_reg;
        popped_next  = popped_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = ole_pkg::op_t'(s_tdata[2:0]);
                    pos_next    = CNT_W'(s_tdata[9:3]);
                    val_next    = s_tdata[41:10];
                    status_next = ole_pkg::STATUS_OK;
                    popped_next = '0;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    cap_next    = 1'b0;
                    state_next  = ole_pkg::ST_DONE;
                    unique case (ole_pkg::op_t'(s_tdata[2:0]))
                        ole_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ole_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[ADDR_W-1:0];
                                mem_wdata  = s_tdata[41:10];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ole_pkg::OP_INSERT:
                        begin
                            if (pos_cmp > cnt_cmp)
                            begin
                                status_next = ole_pkg::STATUS_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ole_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = ole_pkg::ST_SHIFT_UP;
                            end
                        end
                        ole_pkg::OP_POP:
                        begin
                            if (pos_cmp >= cnt_cmp)
                            begin
                                status_next = ole_pkg::STATUS_RANGE;
                                popped_next = '1;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(s_tdata[9:3]);
                                cap_next   = 1'b1;
                                state_next = ole_pkg::ST_SHIFT_DOWN;
                            end
                        end
                        ole_pkg::OP_REMOVE, ole_pkg::OP_FIND:
                        begin
                            ptr_next   = '0;
                            state_next = ole_pkg::ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ole_pkg::ST_SHIFT_UP:
            begin
                // Entry read last cycle lands one place higher.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = paddr_reg + ADDR_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_dec[ADDR_W-1:0];
                    paddr_next = ptr_dec[ADDR_W-1:0];
                    pend_next  = 1'b1;
                    ptr_next   = ptr_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg[ADDR_W-1:0];
                        mem_wdata  = val_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = ole_pkg::ST_DONE;
                    end
                end
            end

            ole_pkg::ST_SHIFT_DOWN:
            begin
                // The first read of a pop returns the popped entry; later reads move down.
                if (pend_reg)
                begin
                    if (cap_reg)
                    begin
                        popped_next = mem_rdata;
                        cap_next    = 1'b0;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = paddr_reg - ADDR_W'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg[ADDR_W-1:0];
                    paddr_next = ptr_reg[ADDR_W-1:0];
                    pend_next  = 1'b1;
                    ptr_next   = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ole_pkg::ST_DONE;
                    end
                end
            end

            ole_pkg::ST_SCAN:
            begin
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    // No further read is issued on a hit; a remove then shifts down from
                    // the entry after the hit.
                    idx_next  = 7'(paddr_reg);
                    pend_next = 1'b0;
                    if (op_reg == ole_pkg::OP_FIND)
                    begin
                        state_next = ole_pkg::ST_DONE;
                    end
                    else
                    begin
                        ptr_next   = CNT_W'(paddr_reg) + CNT_W'(1);
                        cap_next   = 1'b0;
                        state_next = ole_pkg::ST_SHIFT_DOWN;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg[ADDR_W-1:0];
                    paddr_next = ptr_reg[ADDR_W-1:0];
                    pend_next  = 1'b1;
                    ptr_next   = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        status_next = ole_pkg::STATUS_NOTFOUND;
                        idx_next    = '1;
                        state_next  = ole_pkg::ST_DONE;
                    end
                end
            end

            ole_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'(count_reg), idx_reg, popped_reg, status_reg};
                    state_next   = ole_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ole_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ole_pkg::ST_DONE))
        else $error("result presented outside the completion state");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ole_pkg::ST_SCAN || state_reg == ole_pkg::ST_SHIFT_UP ||
         state_reg == ole_pkg::ST_SHIFT_DOWN) |=> (state_reg != ole_pkg::ST_IDLE))
        else $error("work state left without completing the request");

endmodule

// ===== tb/list_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ordered list engine: it mirrors the list, predicts each result and compares.
module list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // req_type[2:0], position[9:3], item_value[41:10], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,    // status[1:0], popped_value[33:2], found_index[40:34],
                                    // entry_count[47:41]
    output int          fail_count,
    output int          pending,
    output int          list_len
);

    // Field order matches the result bus, highest bits first.
    typedef struct packed {
        logic [ole_pkg::COUNT_W-1:0] entry_count;
        logic [ole_pkg::INDEX_W-1:0] found_index;
        logic [ole_pkg::VALUE_W-1:0] popped_value;
        ole_pkg::status_t            status;
    } list_result_t;

    logic [ole_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
    int                          shadow_len;
    list_result_t                expected_results [$];
    list_result_t                actual;
    list_result_t                wanted;
    int                          mismatch_count = 0;

    assign fail_count = mismatch_count;

    function automatic list_result_t predict_request(input logic [47:0] req);
        logic [ole_pkg::OP_W-1:0]    op;
        int                          pos;
        logic [ole_pkg::VALUE_W-1:0] val;
        list_result_t                res;
        int                          hit;
        int                          i;
        op  = req[2:0];
        pos = int'(req[9:3]);
        val = req[41:10];
        res.status       = ole_pkg::STATUS_OK;
        res.popped_value = '0;
        res.found_index  = '0;
        case (op)
            ole_pkg::OP_APPEND:
            begin
                if (shadow_len >= CAPACITY)
                    res.status = ole_pkg::STATUS_FULL;
                else
                begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end
            end
            ole_pkg::OP_INSERT:
            begin
                // The position is checked before the fill level.
                if (pos > shadow_len)
                    res.status = ole_pkg::STATUS_RANGE;
                else if (shadow_len >= CAPACITY)
                    res.status = ole_pkg::STATUS_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[pos] = val;
                    shadow_len++;
                end
            end
            ole_pkg::OP_POP:
            begin
                if (pos >= shadow_len)
                begin
                    res.status       = ole_pkg::STATUS_RANGE;
                    res.popped_value = '1;
                end
                else
                begin
                    res.popped_value = shadow_entries[pos];
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len--;
                end
            end
            ole_pkg::OP_REMOVE, ole_pkg::OP_FIND:
            begin
                hit = shadow_len;
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_entries[i] == val)
                        hit = i;
                if (hit == shadow_len)
                begin
                    res.status      = ole_pkg::STATUS_NOTFOUND;
                    res.found_index = '1;
                end
                else
                begin
                    res.found_index = ole_pkg::INDEX_W'(hit);
                    if (op == ole_pkg::OP_REMOVE)
                    begin
                        for (i = hit; i + 1 < shadow_len; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_len--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = ole_pkg::COUNT_W'(shadow_len);
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] exp_bits,
                                 input logic [31:0] act_bits);
        if (exp_bits !== act_bits)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_bits,
                     act_bits);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
            pending  <= 0;
            list_len <= 0;
        end
        else
        begin
            // A result always belongs to an older request, so it is checked first.
            if (m_tvalid && m_tready)
            begin
                actual = list_result_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0h", $time,
                             m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    compare_field("status", 32'(wanted.status), 32'(actual.status));
                    compare_field("popped_value", wanted.popped_value, actual.popped_value);
                    compare_field("found_index", 32'(wanted.found_index),
                                  32'(actual.found_index));
                    compare_field("entry_count", 32'(wanted.entry_count),
                                  32'(actual.entry_count));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_request(s_tdata));
            pending  <= expected_results.size();
            list_len <= shadow_len;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, requests, output stalls and verdict.
module testbench;

    localparam int CAPACITY        = 64;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int DRAIN_CYCLES    = CAPACITY + 40;
    localparam logic [ole_pkg::OP_W-1:0] OP_SPARE = 3'd5;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int          fail_count;
    int          pending;
    int          list_len;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    ready_mode_t ready_mode    = READY_ALWAYS;
    int          mode_left     = 0;
    logic [7:0]  ready_pattern = 8'hFF;
    int          pattern_phase = 0;

    ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Requests go out in bursts; a new burst always begins with a gap.
    task automatic send_request(input logic [ole_pkg::OP_W-1:0] op,
                                input logic [ole_pkg::POS_W-1:0] pos,
                                input logic [ole_pkg::VALUE_W-1:0] val);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, pos, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Small values and extremes recur often, so that removes and finds get hits.
    function automatic logic [ole_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0, 1, 2: return 32'($urandom_range(0, 15));
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [ole_pkg::OP_W-1:0] pick_op(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            if (roll < 45)
                return ole_pkg::OP_APPEND;
            if (roll < 70)
                return ole_pkg::OP_INSERT;
            if (roll < 80)
                return ole_pkg::OP_POP;
            if (roll < 90)
                return ole_pkg::OP_REMOVE;
            return ole_pkg::OP_FIND;
        end
        if (roll < 10)
            return ole_pkg::OP_APPEND;
        if (roll < 20)
            return ole_pkg::OP_INSERT;
        if (roll < 60)
            return ole_pkg::OP_POP;
        if (roll < 85)
            return ole_pkg::OP_REMOVE;
        return ole_pkg::OP_FIND;
    endfunction

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode    <= ready_mode_t'($urandom_range(0, 3));
            mode_left     <= $urandom_range(50, 400);
            ready_pattern <= 8'($urandom) | 8'h01;
        end
        else
            mode_left <= mode_left - 1;
        pattern_phase <= (pattern_phase + 1) % 8;
        case (ready_mode)
            READY_ALWAYS:  m_tready <= 1'b1;
            READY_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: m_tready <= ready_pattern[pattern_phase];
            default:       m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                           n;
        bit                           growing;
        int                           phase_left;
        logic [ole_pkg::OP_W-1:0]     op;
        logic [ole_pkg::POS_W-1:0]    pos;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests on an empty list.
        send_request(ole_pkg::OP_POP, 7'd0, 32'd0);
        send_request(ole_pkg::OP_FIND, 7'd0, 32'd0);
        send_request(ole_pkg::OP_REMOVE, 7'd0, 32'd5);
        // Value extremes, then inserts at the front, at the end and past the end.
        send_request(ole_pkg::OP_APPEND, 7'd0, 32'h7FFF_FFFF);
        send_request(ole_pkg::OP_APPEND, 7'd0, 32'h8000_0000);
        send_request(ole_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
        send_request(ole_pkg::OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_request(ole_pkg::OP_INSERT, 7'd0, 32'h1234_5678);
        send_request(ole_pkg::OP_INSERT, 7'd5, 32'hA5A5_A5A5);
        send_request(ole_pkg::OP_INSERT, 7'd64, 32'h0000_0001);
        send_request(ole_pkg::OP_INSERT, 7'd7, 32'h0000_0002);
        send_request(ole_pkg::OP_FIND, 7'd127, 32'h8000_0000);
        send_request(ole_pkg::OP_FIND, 7'd0, 32'hDEAD_BEEF);
        send_request(ole_pkg::OP_REMOVE, 7'd0, 32'hFFFF_FFFF);
        // A duplicate value: find must report the first copy.
        send_request(ole_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
        send_request(ole_pkg::OP_FIND, 7'd0, 32'h0000_0000);
        send_request(ole_pkg::OP_POP, 7'd6, 32'd0);
        send_request(ole_pkg::OP_POP, 7'd0, 32'd0);
        send_request(ole_pkg::OP_POP, 7'd4, 32'd0);
        send_request(ole_pkg::OP_POP, 7'd64, 32'd0);
        for (n = 0; n < 3; n++)
            send_request(OP_SPARE + 3'(n), 7'($urandom_range(0, 127)), 32'($urandom));

        // Alternate between filling and draining phases so that the full list is reached.
        growing    = 1'b0;
        phase_left = 0;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (phase_left == 0)
            begin
                growing    = !growing;
                phase_left = $urandom_range(80, 200);
            end
            phase_left--;
            op  = pick_op(growing);
            pos = 7'($urandom_range(0, CAPACITY));
            if (op == ole_pkg::OP_INSERT && $urandom_range(0, 4) != 0)
                pos = 7'($urandom_range(0, list_len));
            else if (op == ole_pkg::OP_POP && list_len > 0 && $urandom_range(0, 4) != 0)
                pos = 7'($urandom_range(0, list_len - 1));
            send_request(op, pos, pick_value());
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ordered_list_engine.sv
tb/list_checker.sv
tb/testbench.sv
